[sv/sdfgc_pkg.sv]
package sdfgc_pkg;

  localparam int X_NODES = 32;
  localparam int Y_NODES = 32;
  localparam int Z_NODES = 32;
  localparam int PASSES  = 3;

  localparam int ADDR_W = 15;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PASS_W = $clog2(PASSES + 1);
  localparam int GW     = 50;
  localparam int CELL_W = 8;

  localparam logic [1:0]  OP_IGNORE = 2'd3;
  localparam logic [31:0] FAR_DIST  = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_DIST = 2'd1,
    OP_CORR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    R_ORIGIN_X, R_ORIGIN_Y, R_ORIGIN_Z,
    R_INV_X, R_INV_Y, R_INV_Z,
    R_TOL, R_RATE
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COORD, ST_LOCATE, ST_READ, ST_LERP, ST_TEST,
    ST_GRAD, ST_STEP, ST_CLAMP, ST_MUL, ST_ADD, ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] node_index;
    logic [31:0]       node_value;
    logic [31:0]       grad_x;
    logic [31:0]       grad_y;
    logic [31:0]       grad_z;
    logic [31:0]       point_x;
    logic [31:0]       point_y;
    logic [31:0]       point_z;
    logic [31:0]       threshold;
  } item_t;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][31:0] inv_step;
    logic [30:0]      tolerance;
    logic [15:0]      rate;
  } cfg_t;

  function automatic int nodes_of(input logic [1:0] a);
    case (a)
      2'd0:    return X_NODES;
      2'd1:    return Y_NODES;
      default: return Z_NODES;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] corner_off(input logic dx, input logic dy,
                                                   input logic dz);
    logic [31:0] s;
    s = 32'(dx) * 32'(Y_NODES * Z_NODES) + 32'(dy) * 32'(Z_NODES) + 32'(dz);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

[sv/sdfgc_ram.sv]
module sdfgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sdfgc_front.sv]
module sdfgc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [1:0]                     op,
  input  logic [sdfgc_pkg::ADDR_W-1:0]   node_index,
  input  logic signed [31:0]             node_value,
  input  logic signed [31:0]             node_grad_x,
  input  logic signed [31:0]             node_grad_y,
  input  logic signed [31:0]             node_grad_z,
  input  logic signed [31:0]             point_x,
  input  logic signed [31:0]             point_y,
  input  logic signed [31:0]             point_z,
  input  logic signed [31:0]             threshold,
  input  logic                           pop,
  output logic                           avail,
  output sdfgc_pkg::item_t               word,
  output logic [1:0]                     fill
);

  sdfgc_pkg::item_t slot [2];
  sdfgc_pkg::item_t in_word;
  logic             wr_ptr;
  logic             rd_ptr;
  logic             push;

  // op 3 words are taken and dropped here
  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall && (op != sdfgc_pkg::OP_IGNORE);
  assign avail      = (fill != 2'd0);
  assign word       = slot[rd_ptr];

  always_comb begin
    in_word.op         = sdfgc_pkg::op_t'(op);
    in_word.node_index = node_index;
    in_word.node_value = node_value;
    in_word.grad_x     = node_grad_x;
    in_word.grad_y     = node_grad_y;
    in_word.grad_z     = node_grad_z;
    in_word.point_x    = point_x;
    in_word.point_y    = point_y;
    in_word.point_z    = point_z;
    in_word.threshold  = threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_word;
    end
  end

endmodule

[sv/sdfgc_back.sv]
module sdfgc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    avail,
  input  sdfgc_pkg::item_t        word,
  output logic                    pop,
  input  sdfgc_pkg::cfg_t         cfg,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [31:0]      distance,
  output logic                    outside,
  output logic                    changed,
  output logic signed [31:0]      corrected_x,
  output logic signed [31:0]      corrected_y,
  output logic signed [31:0]      corrected_z
);

  localparam int AW = sdfgc_pkg::ADDR_W;
  localparam int GW = sdfgc_pkg::GW;

  sdfgc_pkg::state_t st, st_next;
  sdfgc_pkg::item_t  itm;

  logic signed [31:0]             q [3];
  logic                           chg;
  logic [sdfgc_pkg::PASS_W-1:0]   pass;
  logic [1:0]                     ax;
  logic                           half;
  logic signed [65:0]             acc;
  logic signed [GW-1:0]           g [3];
  logic [15:0]                    frac [3];
  logic [AW-1:0]                  base;
  logic signed [31:0]             v [8];
  logic [3:0]                     cnt;
  logic signed [31:0]             cur_d;
  logic                           far;
  logic signed [34:0]             diff;
  logic signed [31:0]             gr [3];
  logic signed [52:0]             sprod;
  logic signed [31:0]             stp;
  logic signed [63:0]             mprod;

  logic                           ram_we;
  logic [AW-1:0]                  val_raddr;
  logic [AW-1:0]                  grad_raddr;
  logic [31:0]                    val_rdata;
  logic [31:0]                    gx_rdata;
  logic [31:0]                    gy_rdata;
  logic [31:0]                    gz_rdata;
  logic                           res_load;

  sdfgc_ram #(.WIDTH(32), .DEPTH(sdfgc_pkg::DEPTH)) u_val (
    .clk(clk), .we(ram_we), .waddr(word.node_index), .wdata(word.node_value),
    .raddr(val_raddr), .rdata(val_rdata)
  );
  sdfgc_ram #(.WIDTH(32), .DEPTH(sdfgc_pkg::DEPTH)) u_gx (
    .clk(clk), .we(ram_we), .waddr(word.node_index), .wdata(word.grad_x),
    .raddr(grad_raddr), .rdata(gx_rdata)
  );
  sdfgc_ram #(.WIDTH(32), .DEPTH(sdfgc_pkg::DEPTH)) u_gy (
    .clk(clk), .we(ram_we), .waddr(word.node_index), .wdata(word.grad_y),
    .raddr(grad_raddr), .rdata(gy_rdata)
  );
  sdfgc_ram #(.WIDTH(32), .DEPTH(sdfgc_pkg::DEPTH)) u_gz (
    .clk(clk), .we(ram_we), .waddr(word.node_index), .wdata(word.grad_z),
    .raddr(grad_raddr), .rdata(gz_rdata)
  );

  // grid coordinate, two 16-bit halves of inv_step
  logic signed [32:0] d_coord;
  logic signed [49:0] p_half;
  logic signed [65:0] acc_sum;

  assign d_coord = $signed({q[ax][31], q[ax]}) -
                   $signed({cfg.origin[ax][31], cfg.origin[ax]});
  assign p_half  = d_coord * $signed({1'b0, half ? cfg.inv_step[ax][31:16]
                                                 : cfg.inv_step[ax][15:0]});
  assign acc_sum = acc + ($signed({{16{p_half[49]}}, p_half}) <<< 16);

  // cell checks
  logic [2:0]  ax_in;
  logic [2:0]  ax_miss;
  logic [31:0] base_lin;

  always_comb begin : locate_chk
    logic signed [GW-1:0] hi;
    for (int a = 0; a < 3; a++) begin
      hi = GW'(sdfgc_pkg::nodes_of(2'(a)) - 1) << 16;
      ax_in[a]   = !g[a][GW-1] &&
                   (g[a][GW-2:16] <= (GW-17)'(sdfgc_pkg::nodes_of(2'(a)) - 2));
      ax_miss[a] = g[a][GW-1] || (g[a] > hi);
    end
  end

  assign base_lin = (32'(g[0][16 +: sdfgc_pkg::CELL_W]) * 32'(sdfgc_pkg::Y_NODES) +
                     32'(g[1][16 +: sdfgc_pkg::CELL_W])) * 32'(sdfgc_pkg::Z_NODES) +
                    32'(g[2][16 +: sdfgc_pkg::CELL_W]);

  // blend unit
  logic [15:0]        lf;
  logic signed [32:0] ldel;
  logic signed [49:0] lprod;
  logic signed [31:0] lres;

  assign lf    = (cnt < 4'd4) ? frac[0] : (cnt < 4'd6) ? frac[1] : frac[2];
  assign ldel  = $signed({v[1][31], v[1]}) - $signed({v[0][31], v[0]});
  assign lprod = ldel * $signed({1'b0, lf});
  assign lres  = v[0] + lprod[47:16];

  // stop test and penetration
  logic signed [31:0] thr;
  logic signed [33:0] limit;
  logic               stop;
  logic signed [63:0] msum;

  assign thr   = $signed(itm.threshold);
  assign limit = $signed({{2{thr[31]}}, thr}) + $signed({3'b000, cfg.tolerance});
  assign stop  = (cur_d > thr) && (!chg || ($signed({{2{cur_d[31]}}, cur_d}) < limit));
  assign msum  = $signed({{32{q[ax][31]}}, q[ax]}) +
                 $signed({{16{mprod[63]}}, mprod[63:16]});

  always_comb begin
    st_next = st;
    case (st)
      sdfgc_pkg::ST_IDLE: begin
        if (avail && word.op != sdfgc_pkg::OP_LOAD) begin
          st_next = sdfgc_pkg::ST_COORD;
        end
      end
      sdfgc_pkg::ST_COORD: begin
        if (ax == 2'd2 && half) begin
          st_next = sdfgc_pkg::ST_LOCATE;
        end
      end
      sdfgc_pkg::ST_LOCATE: begin
        if ((itm.op == sdfgc_pkg::OP_CORR && pass == '0 && (|ax_miss)) || !(&ax_in)) begin
          st_next = sdfgc_pkg::ST_DONE;
        end else begin
          st_next = sdfgc_pkg::ST_READ;
        end
      end
      sdfgc_pkg::ST_READ: begin
        if (cnt == 4'd8) begin
          st_next = sdfgc_pkg::ST_LERP;
        end
      end
      sdfgc_pkg::ST_LERP: begin
        if (cnt == 4'd6) begin
          st_next = (itm.op == sdfgc_pkg::OP_DIST) ? sdfgc_pkg::ST_DONE : sdfgc_pkg::ST_TEST;
        end
      end
      sdfgc_pkg::ST_TEST: begin
        st_next = stop ? sdfgc_pkg::ST_DONE : sdfgc_pkg::ST_GRAD;
      end
      sdfgc_pkg::ST_GRAD:  st_next = sdfgc_pkg::ST_STEP;
      sdfgc_pkg::ST_STEP:  st_next = sdfgc_pkg::ST_CLAMP;
      sdfgc_pkg::ST_CLAMP: st_next = sdfgc_pkg::ST_MUL;
      sdfgc_pkg::ST_MUL:   st_next = sdfgc_pkg::ST_ADD;
      sdfgc_pkg::ST_ADD: begin
        if (ax != 2'd2) begin
          st_next = sdfgc_pkg::ST_MUL;
        end else if (pass == sdfgc_pkg::PASS_W'(sdfgc_pkg::PASSES - 1)) begin
          st_next = sdfgc_pkg::ST_DONE;
        end else begin
          st_next = sdfgc_pkg::ST_COORD;
        end
      end
      sdfgc_pkg::ST_DONE: begin
        if (!result_valid || !result_stall) begin
          st_next = sdfgc_pkg::ST_IDLE;
        end
      end
      default: st_next = sdfgc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = (st == sdfgc_pkg::ST_IDLE) && avail;
    ram_we     = pop && (word.op == sdfgc_pkg::OP_LOAD);
    val_raddr  = base + sdfgc_pkg::corner_off(cnt[0], cnt[1], cnt[2]);
    grad_raddr = base + sdfgc_pkg::corner_off(frac[0][15], frac[1][15], frac[2][15]);
    res_load   = (st == sdfgc_pkg::ST_DONE) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= sdfgc_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      sdfgc_pkg::ST_IDLE: begin
        if (pop && word.op != sdfgc_pkg::OP_LOAD) begin
          itm  <= word;
          q[0] <= $signed(word.point_x);
          q[1] <= $signed(word.point_y);
          q[2] <= $signed(word.point_z);
          chg  <= 1'b0;
          pass <= '0;
          ax   <= 2'd0;
          half <= 1'b0;
          far  <= 1'b0;
        end
      end
      sdfgc_pkg::ST_COORD: begin
        if (!half) begin
          acc  <= $signed({{16{p_half[49]}}, p_half});
          half <= 1'b1;
        end else begin
          g[ax] <= acc_sum[65:16];
          half  <= 1'b0;
          ax    <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
      end
      sdfgc_pkg::ST_LOCATE: begin
        base    <= base_lin[AW-1:0];
        frac[0] <= g[0][15:0];
        frac[1] <= g[1][15:0];
        frac[2] <= g[2][15:0];
        cnt     <= 4'd0;
        if (!(&ax_in)) begin
          cur_d <= $signed(sdfgc_pkg::FAR_DIST);
          far   <= 1'b1;
        end
      end
      sdfgc_pkg::ST_READ: begin
        cnt <= (cnt == 4'd8) ? 4'd0 : cnt + 4'd1;
        if (cnt != 4'd0) begin
          for (int n = 0; n < 7; n++) begin
            v[n] <= v[n+1];
          end
          v[7] <= $signed(val_rdata);
        end
      end
      sdfgc_pkg::ST_LERP: begin
        for (int n = 0; n < 6; n++) begin
          v[n] <= v[n+2];
        end
        v[3'(4'd6 - cnt)] <= lres;
        cnt <= cnt + 4'd1;
        if (cnt == 4'd6) begin
          cur_d <= lres;
        end
      end
      sdfgc_pkg::ST_TEST: begin
        if (cur_d < thr) begin
          diff <= $signed({{3{cur_d[31]}}, cur_d}) - $signed({limit[33], limit});
        end else begin
          diff <= $signed({{3{cur_d[31]}}, cur_d}) - $signed({{3{thr[31]}}, thr});
        end
        ax <= 2'd0;
      end
      sdfgc_pkg::ST_STEP: begin
        gr[0] <= $signed(gx_rdata);
        gr[1] <= $signed(gy_rdata);
        gr[2] <= $signed(gz_rdata);
        sprod <= (-diff) * $signed({1'b0, cfg.rate});
      end
      sdfgc_pkg::ST_CLAMP: begin
        stp <= sdfgc_pkg::sat32($signed({{26{sprod[52]}}, sprod[52:15]}));
      end
      sdfgc_pkg::ST_MUL: begin
        mprod <= gr[ax] * stp;
      end
      sdfgc_pkg::ST_ADD: begin
        q[ax] <= sdfgc_pkg::sat32(msum);
        if (ax == 2'd2) begin
          ax   <= 2'd0;
          chg  <= 1'b1;
          pass <= pass + 1'b1;
        end else begin
          ax <= ax + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (itm.op == sdfgc_pkg::OP_DIST) begin
        distance    <= cur_d;
        outside     <= far;
        changed     <= 1'b0;
        corrected_x <= '0;
        corrected_y <= '0;
        corrected_z <= '0;
      end else begin
        distance    <= '0;
        outside     <= 1'b0;
        changed     <= chg;
        corrected_x <= q[0];
        corrected_y <= q[1];
        corrected_z <= q[2];
      end
    end
  end

endmodule

[sv/sdf_grid_collision_correct_core.sv]
// channel   | handshake                  | payload
// config    | psel penable pwrite pready | paddr pwdata prdata
// item in   | item_valid item_stall      | op node_index node_value node_grad_* point_* threshold
// result    | result_valid result_stall  | distance outside changed corrected_*
//
// A load word is written to the grid RAMs as it is popped from the queue head. A distance
// query runs six grid coordinate multiplies, eight serial reads of the value RAM, seven blends.
// A correction query adds per pass a gradient read, step and three moves, up to PASSES
// passes; the value RAM's single read port serializes the corner reads.
// Synchronous reset; the grid RAMs hold no reset state and need no clearing.
// Two queue words and one result register decouple the item and result sides.
module sdf_grid_collision_correct_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   op,
  input  logic [sdfgc_pkg::ADDR_W-1:0] node_index,
  input  logic signed [31:0]           node_value,
  input  logic signed [31:0]           node_grad_x,
  input  logic signed [31:0]           node_grad_y,
  input  logic signed [31:0]           node_grad_z,
  input  logic signed [31:0]           point_x,
  input  logic signed [31:0]           point_y,
  input  logic signed [31:0]           point_z,
  input  logic signed [31:0]           threshold,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [31:0]           distance,
  output logic                         outside,
  output logic                         changed,
  output logic signed [31:0]           corrected_x,
  output logic signed [31:0]           corrected_y,
  output logic signed [31:0]           corrected_z
);

  sdfgc_pkg::cfg_t  cfg;
  sdfgc_pkg::item_t word;
  sdfgc_pkg::reg_t  ridx;
  logic             avail;
  logic             pop;
  logic [1:0]       fill;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign ridx   = sdfgc_pkg::reg_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin    <= '0;
      cfg.inv_step  <= {3{32'd65536}};
      cfg.tolerance <= '0;
      cfg.rate      <= 16'd31130;
    end else if (cfg_wr) begin
      case (ridx)
        sdfgc_pkg::R_ORIGIN_X: cfg.origin[0]   <= pwdata;
        sdfgc_pkg::R_ORIGIN_Y: cfg.origin[1]   <= pwdata;
        sdfgc_pkg::R_ORIGIN_Z: cfg.origin[2]   <= pwdata;
        sdfgc_pkg::R_INV_X:    cfg.inv_step[0] <= pwdata;
        sdfgc_pkg::R_INV_Y:    cfg.inv_step[1] <= pwdata;
        sdfgc_pkg::R_INV_Z:    cfg.inv_step[2] <= pwdata;
        sdfgc_pkg::R_TOL:      cfg.tolerance   <= pwdata[30:0];
        sdfgc_pkg::R_RATE:     cfg.rate        <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      sdfgc_pkg::R_ORIGIN_X: prdata = cfg.origin[0];
      sdfgc_pkg::R_ORIGIN_Y: prdata = cfg.origin[1];
      sdfgc_pkg::R_ORIGIN_Z: prdata = cfg.origin[2];
      sdfgc_pkg::R_INV_X:    prdata = cfg.inv_step[0];
      sdfgc_pkg::R_INV_Y:    prdata = cfg.inv_step[1];
      sdfgc_pkg::R_INV_Z:    prdata = cfg.inv_step[2];
      sdfgc_pkg::R_TOL:      prdata = {1'b0, cfg.tolerance};
      sdfgc_pkg::R_RATE:     prdata = {16'd0, cfg.rate};
      default:               prdata = '0;
    endcase
  end

  sdfgc_front u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .node_index(node_index), .node_value(node_value),
    .node_grad_x(node_grad_x), .node_grad_y(node_grad_y), .node_grad_z(node_grad_z),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .threshold(threshold),
    .pop(pop), .avail(avail), .word(word), .fill(fill)
  );

  sdfgc_back u_back (
    .clk(clk), .rst(rst),
    .avail(avail), .word(word), .pop(pop), .cfg(cfg),
    .result_valid(result_valid), .result_stall(result_stall),
    .distance(distance), .outside(outside), .changed(changed),
    .corrected_x(corrected_x), .corrected_y(corrected_y), .corrected_z(corrected_z)
  );

  a_queue_takes: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (op != sdfgc_pkg::OP_IGNORE) |=> fill != 2'd0)
    else $error("accepted word missing from queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != 2'd0)
    else $error("queue popped while empty");

  a_far_outside: assert property (@(posedge clk) disable iff (rst)
    result_valid && outside |-> distance == $signed(sdfgc_pkg::FAR_DIST) && !changed)
    else $error("outside result with bad distance");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && changed |-> !outside && distance == 32'sd0)
    else $error("correction result carries distance fields");

endmodule
